// ===== rtl/core/hbp_pkg.sv =====
// hbp_pkg: shared types and constants for the pipeline hazard / branch predict block
// instruction kind codes, per-stage record, result record, predictor sizing
// no dependencies
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int XLEN         = 32;
  localparam int REG_W        = 5;
  localparam int KIND_W       = 4;
  localparam int NSTAGE       = 5;
  localparam int PRED_ENTRIES = 64;
  localparam int PRED_IDX_W   = $clog2(PRED_ENTRIES);
  localparam int PRED_SHIFT   = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [REG_W-1:0]      regnum_t;
  typedef logic [XLEN-1:0]       word_t;
  typedef logic [PRED_IDX_W-1:0] pred_idx_t;

  localparam kind_t KIND_NOP    = kind_t'(0);
  localparam kind_t KIND_RTYPE  = kind_t'(1);
  localparam kind_t KIND_ITYPE  = kind_t'(2);
  localparam kind_t KIND_LOAD   = kind_t'(3);
  localparam kind_t KIND_STORE  = kind_t'(4);
  localparam kind_t KIND_BRANCH = kind_t'(5);
  localparam kind_t KIND_JTYPE  = kind_t'(6);
  localparam kind_t KIND_JRTYPE = kind_t'(8);

  // one pipeline stage, with decode flags worked out at fetch
  typedef struct packed {
    kind_t   kind;
    regnum_t rs_a;
    regnum_t rs_b;
    regnum_t rd;
    word_t   pc;
    word_t   tgt;
    logic    uses_a;
    logic    uses_b;
    logic    is_load;
    logic    is_cti;
  } stage_t;

  localparam stage_t STAGE_CLEAR = '0;

  typedef struct packed {
    kind_t kind;
    word_t pc;
    logic  stall;
    logic  squash;
    logic  empty;
    word_t count;
    logic  last;
  } result_t;

  function automatic pred_idx_t pred_index(input word_t pc);
    pred_index = pc[PRED_SHIFT +: PRED_IDX_W];
  endfunction

endpackage

// ===== rtl/core/hbp_in_if.sv =====
// hbp_in_if: request channel carrying one trace instruction or drain request
// depends on hbp_pkg
`timescale 1ns / 1ps

interface hbp_in_if import hbp_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    has_instr;
  kind_t   instr_kind;
  regnum_t src_reg_a;
  regnum_t src_reg_b;
  regnum_t dest_reg;
  word_t   instr_pc;
  word_t   target_addr;

  modport source (
    output valid, has_instr, instr_kind, src_reg_a, src_reg_b, dest_reg,
           instr_pc, target_addr,
    input  ready
  );
  modport sink (
    input  valid, has_instr, instr_kind, src_reg_a, src_reg_b, dest_reg,
           instr_pc, target_addr,
    output ready
  );
endinterface

// ===== rtl/core/hbp_out_if.sv =====
// hbp_out_if: result channel, one request per simulated pipeline cycle
// depends on hbp_pkg
`timescale 1ns / 1ps

interface hbp_out_if import hbp_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t retired_kind;
  word_t retired_pc;
  logic  stall_cycle;
  logic  squash_cycle;
  logic  pipe_empty;
  word_t cycle_count;
  logic  last_of_run;

  modport source (
    output valid, retired_kind, retired_pc, stall_cycle, squash_cycle, pipe_empty,
           cycle_count, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, retired_kind, retired_pc, stall_cycle, squash_cycle, pipe_empty,
           cycle_count, last_of_run,
    output ready
  );
endinterface

// ===== rtl/core/hbp_front.sv =====
// hbp_front: accepts fetch requests and decodes them into stage records
// depends on hbp_pkg, hbp_in_if
`timescale 1ns / 1ps

module hbp_front import hbp_pkg::*; (
  hbp_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_push,
  output stage_t  q_item
);

  stage_t item;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    item = STAGE_CLEAR;
    // drain request fetches a plain nop
    if (in_ch.has_instr) begin
      item.kind = in_ch.instr_kind;
      item.rs_a = in_ch.src_reg_a;
      item.rs_b = in_ch.src_reg_b;
      item.rd   = in_ch.dest_reg;
      item.pc   = in_ch.instr_pc;
      item.tgt  = in_ch.target_addr;
      case (in_ch.instr_kind)
        KIND_RTYPE, KIND_BRANCH: begin
          item.uses_a = 1'b1;
          item.uses_b = 1'b1;
        end
        KIND_ITYPE, KIND_STORE: begin
          item.uses_a = 1'b1;
        end
        KIND_LOAD: begin
          item.is_load = 1'b1;
        end
        default: begin
        end
      endcase
      item.is_cti = (in_ch.instr_kind == KIND_BRANCH) || (in_ch.instr_kind == KIND_JTYPE) ||
                    (in_ch.instr_kind == KIND_JRTYPE);
    end
  end

  assign q_item = item;

endmodule

// ===== rtl/core/hbp_queue.sv =====
// hbp_queue: short fifo of decoded stage records between front and back
// depends on hbp_pkg
`timescale 1ns / 1ps

module hbp_queue import hbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  stage_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output stage_t head_item
);

  stage_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/hbp_back.sv =====
// hbp_back: five-stage pipeline state, load-use stall, branch check, predictor table
// and the result register; depends on hbp_pkg, hbp_out_if
`timescale 1ns / 1ps

module hbp_back import hbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  input  logic   q_valid,
  input  stage_t q_item,
  output logic   q_pop,
  hbp_out_if.source out_ch
);

  // stage 0 IF, 1 ID, 2 EX, 3 MEM, 4 WB
  stage_t    stg_r [NSTAGE];
  stage_t    stg_nxt [NSTAGE];
  word_t     cnt_r, cnt_nxt;
  logic      mode_r;
  logic      stall_pend_r, stall_pend_nxt;
  result_t   res_r, res_nxt;
  logic      res_vld_r, res_vld_nxt;

  logic      pred_mem [PRED_ENTRIES];
  logic [PRED_ENTRIES-1:0] pred_vld_r;
  logic      pred_bit_r;

  logic      adv, fetch_go, stall_go, step;
  logic      bit_taken, br_chk, miss, hazard, empty;
  stage_t    new_id, new_if;
  logic      pred_we, pred_wval;
  pred_idx_t pred_widx, pred_ridx;

  assign adv      = !res_vld_r || out_ch.ready;
  assign fetch_go = adv && !stall_pend_r && q_valid;
  assign stall_go = adv && stall_pend_r;
  assign step     = fetch_go || stall_go;
  assign q_pop    = fetch_go;

  always_comb begin
    // after the advance EX holds the old ID and ID the old IF
    bit_taken = mode_r && pred_bit_r;
    br_chk    = stg_r[1].is_cti && (stg_r[0].kind != KIND_NOP);
    if (bit_taken) begin
      miss = br_chk && (stg_r[1].tgt != stg_r[0].pc);
    end else begin
      miss = br_chk && (stg_r[0].pc != stg_r[1].pc + PC_STEP);
    end
    new_id = miss ? STAGE_CLEAR : stg_r[0];
    new_if = miss ? STAGE_CLEAR : q_item;
    hazard = new_id.is_load &&
             ((new_if.uses_a && (new_if.rs_a == new_id.rd)) ||
              (new_if.uses_b && (new_if.rs_b == new_id.rd)));

    pred_we   = fetch_go && miss && mode_r;
    pred_widx = pred_index(stg_r[1].pc);
    pred_wval = !bit_taken;
  end

  always_comb begin
    for (int s = 0; s < NSTAGE; s++) begin
      stg_nxt[s] = stg_r[s];
    end
    if (step) begin
      for (int s = 2; s < NSTAGE; s++) begin
        stg_nxt[s] = stg_r[s-1];
      end
      if (fetch_go) begin
        stg_nxt[1] = new_id;
        stg_nxt[0] = new_if;
      end else begin
        // stall cycle: bubble into ID, IF holds
        stg_nxt[1] = STAGE_CLEAR;
      end
    end
    empty = 1'b1;
    for (int s = 0; s < NSTAGE; s++) begin
      if (stg_nxt[s].kind != KIND_NOP) begin
        empty = 1'b0;
      end
    end
    // next EX candidate sits in ID; read its predictor entry ahead
    pred_ridx = pred_index(stg_nxt[1].pc);
  end

  always_comb begin
    cnt_nxt        = step ? cnt_r + 1'b1 : cnt_r;
    stall_pend_nxt = stall_pend_r;
    if (fetch_go) begin
      stall_pend_nxt = hazard;
    end else if (stall_go) begin
      stall_pend_nxt = 1'b0;
    end

    res_nxt        = res_r;
    res_vld_nxt    = res_vld_r && !out_ch.ready;
    if (step) begin
      res_nxt.kind   = stg_nxt[4].kind;
      res_nxt.pc     = stg_nxt[4].pc;
      res_nxt.stall  = stall_go;
      res_nxt.squash = fetch_go && miss;
      res_nxt.empty  = empty;
      res_nxt.count  = cnt_nxt;
      res_nxt.last   = stall_go || !hazard;
      res_vld_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTAGE; s++) begin
        stg_r[s] <= STAGE_CLEAR;
      end
      cnt_r        <= '0;
      mode_r       <= 1'b0;
      stall_pend_r <= 1'b0;
      res_vld_r    <= 1'b0;
      pred_vld_r   <= '0;
      pred_bit_r   <= 1'b0;
    end else begin
      stg_r        <= stg_nxt;
      cnt_r        <= cnt_nxt;
      stall_pend_r <= stall_pend_nxt;
      res_vld_r    <= res_vld_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (pred_we) begin
        pred_vld_r[pred_widx] <= 1'b1;
      end
      // write-through when the entry just flipped is the one being read
      if (pred_we && (pred_widx == pred_ridx)) begin
        pred_bit_r <= pred_wval;
      end else begin
        pred_bit_r <= pred_vld_r[pred_ridx] && pred_mem[pred_ridx];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (pred_we) begin
      pred_mem[pred_widx] <= pred_wval;
    end
  end

  assign out_ch.valid        = res_vld_r;
  assign out_ch.retired_kind = res_r.kind;
  assign out_ch.retired_pc   = res_r.pc;
  assign out_ch.stall_cycle  = res_r.stall;
  assign out_ch.squash_cycle = res_r.squash;
  assign out_ch.pipe_empty   = res_r.empty;
  assign out_ch.cycle_count  = res_r.count;
  assign out_ch.last_of_run  = res_r.last;

endmodule

// ===== rtl/core/pipeline_hazard_branch_predict_top.sv =====
// pipeline_hazard_branch_predict_top: top level of the five-stage pipeline model
// depends on hbp_pkg, hbp_in_if, hbp_out_if, hbp_front, hbp_queue, hbp_back
`timescale 1ns / 1ps

// Each request on in_ch is one fetch cycle of a modeled IF/ID/EX/MEM/WB pipeline and
// gives one result on out_ch; a fetch that reads the destination of a load sitting in
// ID gives a second result, the stall cycle, in which the back end takes no request.
// So the block takes one request per clock, but not in a stall cycle or while out_ch
// holds back a result, set by the single pipeline-state update in the back end. A
// two-entry queue sits between the decoding front end and the back end, and a result
// register drives out_ch, so in_ch keeps accepting while a result waits until the
// queue holds two requests. out_ch.valid is registered: a taken request passes
// through the queue and then the result register. predict_mode (cfg_wdata on cfg_we)
// picks static not-taken (0) or the 64-entry one-bit predictor (1); the table reads
// as not-taken right after reset through per-entry valid flags: no clearing pass.
module pipeline_hazard_branch_predict_top import hbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  hbp_in_if.sink    in_ch,
  hbp_out_if.source out_ch
);

  logic   q_push, q_full, q_pop, q_valid;
  stage_t q_in_item, q_head_item;

  hbp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in_item)
  );

  hbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head_item)
  );

  hbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_head_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
